### hdl/afc_pkg.sv
// Package for the axis-aligned box frustum culling block.
// Holds the fixed-point widths, register map constants, types and helper functions.
// No dependencies.
`default_nettype none

package afc_pkg;

    localparam int COORD_W    = 28;
    localparam int NORMAL_W   = 12;
    localparam int CHUNK_W    = 16;
    localparam int EXTENT_W   = 16;
    localparam int PLANE_W    = 64;
    localparam int PLANE_COUNT = 6;
    localparam int AXES       = 3;
    localparam int OFFSET_LSB = 36;
    localparam int D_SHIFT    = 10;

    localparam int BASE_W = CHUNK_W + EXTENT_W + 1;
    localparam int HI_W   = BASE_W + 1;
    localparam int PROD_W = NORMAL_W + COORD_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 6;
    localparam int REG_ADDR_LSB = 3;
    localparam int IDX_W        = ADDR_W - REG_ADDR_LSB;

    localparam logic [IDX_W-1:0]    REG_CHUNK_EXTENT   = IDX_W'(6);
    localparam logic [EXTENT_W-1:0] CHUNK_EXTENT_RESET = EXTENT_W'(4096);

    localparam logic signed [HI_W-1:0] COORD_MAX_W = HI_W'(134217727);
    localparam logic signed [HI_W-1:0] COORD_MIN_W = -HI_W'(134217728);

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [NORMAL_W-1:0] normal_t;
    typedef logic signed [CHUNK_W-1:0]  chunk_t;
    typedef logic [PLANE_W-1:0]         plane_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [BASE_W-1:0]   base_t;

    function automatic normal_t normal_of(input plane_t plane, input int axis);
        normal_of = plane[NORMAL_W*axis +: NORMAL_W];
    endfunction

    function automatic coord_t offset_of(input plane_t plane);
        offset_of = plane[PLANE_W-1:OFFSET_LSB];
    endfunction

    function automatic coord_t clamp_coord(input logic signed [HI_W-1:0] v);
        if (v > COORD_MAX_W)
        begin
            clamp_coord = COORD_MAX_W[COORD_W-1:0];
        end
        else if (v < COORD_MIN_W)
        begin
            clamp_coord = COORD_MIN_W[COORD_W-1:0];
        end
        else
        begin
            clamp_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### hdl/afc_if.sv
// Stream interfaces for box requests and cull verdicts.
// Depends on afc_pkg for the field types.
`default_nettype none

interface afc_box_if;
    logic            valid;
    logic            ready;
    logic            command;
    afc_pkg::coord_t box_min_x;
    afc_pkg::coord_t box_min_y;
    afc_pkg::coord_t box_min_z;
    afc_pkg::coord_t box_max_x;
    afc_pkg::coord_t box_max_y;
    afc_pkg::coord_t box_max_z;
    afc_pkg::chunk_t chunk_x;
    afc_pkg::chunk_t chunk_y;
    afc_pkg::chunk_t chunk_z;

    modport source (output valid, command, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, chunk_x, chunk_y, chunk_z,
                    input ready);
    modport sink (input valid, command, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, chunk_x, chunk_y, chunk_z,
                  output ready);
endinterface

interface afc_verdict_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

### hdl/aabb_frustum_cull_top.sv
// Top level of the axis-aligned box frustum culling block.
// Depends on afc_pkg and the stream interfaces in afc_if.sv.
//
// Boxes enter on the boxes channel and one verdict per transaction leaves on the
// verdicts channel, in order. A transaction with command 0 tests the given box; with
// command 1 it tests the cube of one chunk, whose corners are the chunk coordinates
// times the chunk extent, saturated to the coordinate range.
// The six planes and the chunk extent are written through the APB port at byte
// address 8 times the register index; writes are to be made only while no box is
// in flight, and the block itself does not enforce this. The pipeline has four
// register stages: the chunk multiply, the corner select and saturation, the
// eighteen normal-by-corner products, and the plane sums that fill the output
// register. One box is accepted in every cycle while the receiver takes verdicts.
// When the receiver stalls, each stage holds its transaction and the stages behind
// it keep filling until the pipeline is full, so no transaction is lost or repeated.
// Reset clears all valid bits, sets the planes to zero and the chunk extent to 16.0.
`default_nettype none

module aabb_frustum_cull_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [afc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [afc_pkg::DATA_W-1:0] pwdata,
    output logic      [afc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    afc_box_if.sink                         boxes,
    afc_verdict_if.source                   verdicts
);
    import afc_pkg::*;

    plane_t              plane_reg [PLANE_COUNT];
    logic [EXTENT_W-1:0] chunk_extent_reg;
    logic [IDX_W-1:0]    reg_idx;
    logic                cfg_write;

    logic   v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic   rdy1, rdy2, rdy3, rdy_out;

    logic   cmd1_reg;
    coord_t box_lo1_reg [AXES];
    coord_t box_hi1_reg [AXES];
    base_t  base1_reg   [AXES];
    base_t  base_next   [AXES];
    chunk_t chunk_in    [AXES];

    coord_t lo2_reg [AXES];
    coord_t hi2_reg [AXES];

    prod_t  prod3_reg [PLANE_COUNT][AXES];

    logic   visible_reg;
    logic   visible_next;
    logic [PLANE_COUNT-1:0] plane_pass;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:REG_ADDR_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
            chunk_extent_reg <= CHUNK_EXTENT_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_idx < IDX_W'(PLANE_COUNT))
            begin
                plane_reg[reg_idx] <= pwdata;
            end
            else if (reg_idx == REG_CHUNK_EXTENT)
            begin
                chunk_extent_reg <= pwdata[EXTENT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_idx < IDX_W'(PLANE_COUNT))
        begin
            prdata = plane_reg[reg_idx];
        end
        else if (reg_idx == REG_CHUNK_EXTENT)
        begin
            prdata = DATA_W'(chunk_extent_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign rdy_out      = !out_valid_reg || verdicts.ready;
    assign rdy3         = !v3_reg || rdy_out;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign boxes.ready  = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= boxes.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    assign chunk_in[0] = boxes.chunk_x;
    assign chunk_in[1] = boxes.chunk_y;
    assign chunk_in[2] = boxes.chunk_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            base_next[a] = BASE_W'(chunk_in[a]) * BASE_W'(signed'({1'b0, chunk_extent_reg}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (boxes.valid && rdy1)
        begin
            cmd1_reg       <= boxes.command;
            box_lo1_reg[0] <= boxes.box_min_x;
            box_lo1_reg[1] <= boxes.box_min_y;
            box_lo1_reg[2] <= boxes.box_min_z;
            box_hi1_reg[0] <= boxes.box_max_x;
            box_hi1_reg[1] <= boxes.box_max_y;
            box_hi1_reg[2] <= boxes.box_max_z;
            for (int a = 0; a < AXES; a++)
            begin
                base1_reg[a] <= base_next[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (cmd1_reg)
                begin
                    lo2_reg[a] <= clamp_coord(HI_W'(base1_reg[a]));
                    hi2_reg[a] <= clamp_coord(HI_W'(base1_reg[a])
                                              + HI_W'(signed'({1'b0, chunk_extent_reg})));
                end
                else
                begin
                    lo2_reg[a] <= box_lo1_reg[a];
                    hi2_reg[a] <= box_hi1_reg[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    if (normal_of(plane_reg[p], a) < 0)
                    begin
                        prod3_reg[p][a] <= PROD_W'(normal_of(plane_reg[p], a))
                                           * PROD_W'(lo2_reg[a]);
                    end
                    else
                    begin
                        prod3_reg[p][a] <= PROD_W'(normal_of(plane_reg[p], a))
                                           * PROD_W'(hi2_reg[a]);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            sum_t plane_sum;
            plane_sum = SUM_W'(prod3_reg[p][0]) + SUM_W'(prod3_reg[p][1])
                        + SUM_W'(prod3_reg[p][2])
                        + (SUM_W'(offset_of(plane_reg[p])) <<< D_SHIFT);
            plane_pass[p] = !plane_sum[SUM_W-1];
        end
        visible_next = &plane_pass;
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && rdy_out)
        begin
            visible_reg <= visible_next;
        end
    end

    assign verdicts.valid   = out_valid_reg;
    assign verdicts.visible = visible_reg;

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg)
        else $error("stage one dropped a stalled transaction");

    a_stage3_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && rdy_out |=> out_valid_reg)
        else $error("stage three transaction did not reach the output register");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && out_valid_reg && !verdicts.ready |-> !boxes.ready)
        else $error("new box accepted into a full stalled pipeline");

    a_extent_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && reg_idx == REG_CHUNK_EXTENT
        |=> chunk_extent_reg == $past(pwdata[EXTENT_W-1:0]))
        else $error("chunk extent write not taken");

endmodule

`default_nettype wire

### tb/sv/tb_aabb_frustum_cull_top.sv
// Self-checking testbench for aabb_frustum_cull_top: drives box and chunk transactions,
// programs the planes over APB and compares every verdict with its own cull predictor.
// Depends on afc_pkg, the stream interfaces in afc_if.sv and the top level.
`default_nettype none

module tb_aabb_frustum_cull_top;
    import afc_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int PIPE_DEPTH      = 4;
    localparam int RUN_LIMIT       = 2000000;
    localparam int ONE             = 256;
    localparam int C_MAX           = 134217727;
    localparam int C_MIN           = -134217728;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 56;

    typedef enum int
    {
        REG_PLANE_LEFT,
        REG_PLANE_RIGHT,
        REG_PLANE_BOTTOM,
        REG_PLANE_TOP,
        REG_PLANE_NEAR,
        REG_PLANE_FAR,
        REG_EXTENT,
        REG_SPARE
    } reg_index_e;

    typedef enum logic
    {
        CMD_BOX   = 1'b0,
        CMD_CHUNK = 1'b1
    } command_e;

    typedef struct packed
    {
        logic                            command;
        logic [AXES-1:0][COORD_W-1:0]    lo;
        logic [AXES-1:0][COORD_W-1:0]    hi;
        logic [AXES-1:0][CHUNK_W-1:0]    chunk;
    } box_txn_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    afc_box_if     boxes ();
    afc_verdict_if verdicts ();

    aabb_frustum_cull_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .boxes    (boxes),
        .verdicts (verdicts)
    );

    plane_t          plane_regs [PLANE_COUNT];
    logic [15:0]     extent_reg;
    box_txn_t        box_queue [$];
    logic            visible_expected [$];
    box_txn_t        box_on_bus;
    logic            box_taken;
    int              src_wait;
    int              snk_wait;
    bit              src_idle_on;
    bit              snk_idle_on;
    int              mismatch_count;

    function automatic longint saturate_coord(input longint v);
        if (v > C_MAX)
        begin
            return C_MAX;
        end
        if (v < C_MIN)
        begin
            return C_MIN;
        end
        return v;
    endfunction

    function automatic logic predict_visible(input box_txn_t t);
        longint  lo_c [AXES];
        longint  hi_c [AXES];
        longint  base;
        longint  sum;
        normal_t n;
        coord_t  d;
        logic    vis;
        vis = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            if (t.command == CMD_CHUNK)
            begin
                base = longint'($signed(t.chunk[a])) * longint'(extent_reg);
                lo_c[a] = saturate_coord(base);
                hi_c[a] = saturate_coord(base + longint'(extent_reg));
            end
            else
            begin
                lo_c[a] = longint'($signed(t.lo[a]));
                hi_c[a] = longint'($signed(t.hi[a]));
            end
        end
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            d = plane_regs[p][PLANE_W-1:OFFSET_LSB];
            sum = longint'(d) * 1024;
            for (int a = 0; a < AXES; a++)
            begin
                n = plane_regs[p][NORMAL_W*a +: NORMAL_W];
                sum += longint'(n) * ((n >= 0) ? hi_c[a] : lo_c[a]);
            end
            if (sum < 0)
            begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic plane_t pack_plane(input int nx, input int ny, input int nz, input int d);
        return {d[COORD_W-1:0], nz[NORMAL_W-1:0], ny[NORMAL_W-1:0], nx[NORMAL_W-1:0]};
    endfunction

    function automatic int neg_normal(input int v);
        return (v == -2048) ? 2047 : -v;
    endfunction

    function automatic box_txn_t make_box(input int x0, input int y0, input int z0,
                                          input int x1, input int y1, input int z1);
        box_txn_t t;
        t.command = CMD_BOX;
        t.lo = {z0[COORD_W-1:0], y0[COORD_W-1:0], x0[COORD_W-1:0]};
        t.hi = {z1[COORD_W-1:0], y1[COORD_W-1:0], x1[COORD_W-1:0]};
        t.chunk = 48'({$urandom(), $urandom()});
        return t;
    endfunction

    function automatic box_txn_t make_chunk(input int cx, input int cy, input int cz);
        box_txn_t t;
        t.command = CMD_CHUNK;
        t.lo = 84'({$urandom(), $urandom(), $urandom()});
        t.hi = 84'({$urandom(), $urandom(), $urandom()});
        t.chunk = {cz[CHUNK_W-1:0], cy[CHUNK_W-1:0], cx[CHUNK_W-1:0]};
        return t;
    endfunction

    function automatic box_txn_t random_box(input int span);
        box_txn_t t;
        int       c;
        int       size;
        int       r;
        t = make_chunk(0, 0, 0);
        t.chunk = 48'({$urandom(), $urandom()});
        t.command = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15)
        begin
            return t;
        end
        t.command = ($urandom_range(0, 99) < 35) ? CMD_CHUNK : CMD_BOX;
        r = span / 4 / int'(extent_reg) + 1;
        if (r > 32767)
        begin
            r = 32767;
        end
        for (int a = 0; a < AXES; a++)
        begin
            c = int'($urandom_range(0, span / 2)) - span / 4;
            size = $urandom_range(0, span / 8);
            if ($urandom_range(0, 99) < 5)
            begin
                t.lo[a] = COORD_W'(c + size);
                t.hi[a] = COORD_W'(c);
            end
            else
            begin
                t.lo[a] = COORD_W'(c);
                t.hi[a] = COORD_W'(c + size);
            end
            t.chunk[a] = CHUNK_W'(int'($urandom_range(0, 2 * r)) - r);
        end
        return t;
    endfunction

    function automatic int pick_idle(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic cfg_write(input int idx, input plane_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << REG_ADDR_LSB);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < PLANE_COUNT)
        begin
            plane_regs[idx] = value;
        end
        else if (idx == REG_EXTENT)
        begin
            extent_reg = value[15:0];
        end
    endtask

    task automatic wait_idle();
        while (box_queue.size() != 0 || boxes.valid || visible_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        box_taken <= boxes.valid && boxes.ready;
        if (rst_n && boxes.valid && boxes.ready)
        begin
            visible_expected.push_back(predict_visible(box_on_bus));
        end
    end

    always @(negedge clk)
    begin
        box_txn_t t;
        if (rst_n && (!boxes.valid || box_taken))
        begin
            if (src_wait > 0)
            begin
                src_wait <= src_wait - 1;
                boxes.valid <= 1'b0;
            end
            else if (box_queue.size() != 0)
            begin
                t = box_queue.pop_front();
                box_on_bus        <= t;
                boxes.command     <= t.command;
                boxes.box_min_x   <= t.lo[0];
                boxes.box_min_y   <= t.lo[1];
                boxes.box_min_z   <= t.lo[2];
                boxes.box_max_x   <= t.hi[0];
                boxes.box_max_y   <= t.hi[1];
                boxes.box_max_z   <= t.hi[2];
                boxes.chunk_x     <= t.chunk[0];
                boxes.chunk_y     <= t.chunk[1];
                boxes.chunk_z     <= t.chunk[2];
                boxes.valid       <= 1'b1;
                src_wait          <= pick_idle(src_idle_on);
            end
            else
            begin
                boxes.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_wait > 0)
            begin
                snk_wait <= snk_wait - 1;
                verdicts.ready <= 1'b0;
            end
            else
            begin
                verdicts.ready <= 1'b1;
                snk_wait <= pick_idle(snk_idle_on);
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && verdicts.valid && verdicts.ready)
        begin
            if (visible_expected.size() == 0)
            begin
                $error("verdict transaction with no box outstanding, visible %0b",
                       verdicts.visible);
                mismatch_count++;
            end
            else
            begin
                want = visible_expected.pop_front();
                if (verdicts.visible !== want)
                begin
                    $error("visible mismatch: expected %0b, actual %0b", want,
                           verdicts.visible);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int span;
        int nx;
        int ny;
        int nz;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        boxes.valid = 1'b0;
        boxes.command = CMD_BOX;
        boxes.box_min_x = '0;
        boxes.box_min_y = '0;
        boxes.box_min_z = '0;
        boxes.box_max_x = '0;
        boxes.box_max_y = '0;
        boxes.box_max_z = '0;
        boxes.chunk_x = '0;
        boxes.chunk_y = '0;
        boxes.chunk_z = '0;
        verdicts.ready = 1'b0;
        box_on_bus = '0;
        box_taken = 1'b0;
        src_wait = 0;
        snk_wait = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        mismatch_count = 0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            plane_regs[p] = '0;
        end
        extent_reg = CHUNK_EXTENT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Planes are all zero after reset, so every box is visible.
        box_queue.push_back(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        box_queue.push_back(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        box_queue.push_back(make_chunk(-32768, 32767, 0));
        wait_idle();

        // Slab from 0 to 100 on every axis; the spare address must not disturb it.
        cfg_write(REG_PLANE_LEFT,   pack_plane(1024, 0, 0, 0));
        cfg_write(REG_PLANE_RIGHT,  pack_plane(-1024, 0, 0, 100 * ONE));
        cfg_write(REG_PLANE_BOTTOM, pack_plane(0, 1024, 0, 0));
        cfg_write(REG_PLANE_TOP,    pack_plane(0, -1024, 0, 100 * ONE));
        cfg_write(REG_PLANE_NEAR,   pack_plane(0, 0, 1024, 0));
        cfg_write(REG_PLANE_FAR,    pack_plane(0, 0, -1024, 100 * ONE));
        cfg_write(REG_EXTENT, 64'd4096);
        cfg_write(REG_SPARE, {$urandom(), $urandom()});
        box_queue.push_back(make_box(10 * ONE, 10 * ONE, 10 * ONE, 20 * ONE, 20 * ONE, 20 * ONE));
        box_queue.push_back(make_box(-5 * ONE, 10 * ONE, 10 * ONE, 0, 20 * ONE, 20 * ONE));
        box_queue.push_back(make_box(-5 * ONE, 10 * ONE, 10 * ONE, -1, 20 * ONE, 20 * ONE));
        box_queue.push_back(make_box(100 * ONE, 10 * ONE, 10 * ONE, 120 * ONE, 20 * ONE, 20 * ONE));
        box_queue.push_back(make_box(100 * ONE + 1, 10 * ONE, 10 * ONE, 120 * ONE, 20 * ONE,
                                     20 * ONE));
        box_queue.push_back(make_box(10 * ONE, 101 * ONE, 10 * ONE, 20 * ONE, 120 * ONE, 20 * ONE));
        box_queue.push_back(make_box(10 * ONE, 10 * ONE, -20 * ONE, 20 * ONE, 20 * ONE, -ONE));
        box_queue.push_back(make_box(50 * ONE, 60 * ONE, 10 * ONE, -5 * ONE, 40 * ONE, 20 * ONE));
        box_queue.push_back(make_box(-1000 * ONE, -1000 * ONE, -1000 * ONE, 1000 * ONE,
                                     1000 * ONE, 1000 * ONE));
        box_queue.push_back(make_chunk(0, 0, 0));
        box_queue.push_back(make_chunk(-1, 0, 0));
        box_queue.push_back(make_chunk(-2, 0, 0));
        box_queue.push_back(make_chunk(6, 6, 6));
        box_queue.push_back(make_chunk(7, 0, 0));
        wait_idle();

        // Largest chunk extent: chunk corners saturate at both ends of the range.
        cfg_write(REG_PLANE_RIGHT,  '0);
        cfg_write(REG_PLANE_BOTTOM, '0);
        cfg_write(REG_PLANE_TOP,    '0);
        cfg_write(REG_PLANE_NEAR,   '0);
        cfg_write(REG_PLANE_FAR,    '0);
        cfg_write(REG_EXTENT, 64'd65535);
        box_queue.push_back(make_chunk(32767, 0, 0));
        box_queue.push_back(make_chunk(-32768, 0, 0));
        box_queue.push_back(make_chunk(-1, 5, -5));
        wait_idle();

        cfg_write(REG_EXTENT, 64'd1);
        box_queue.push_back(make_chunk(-1, 0, 0));
        box_queue.push_back(make_chunk(-2, 0, 0));
        wait_idle();

        // Extreme normals and offsets.
        cfg_write(REG_PLANE_LEFT,   pack_plane(-2048, 2047, 0, C_MAX));
        cfg_write(REG_PLANE_RIGHT,  pack_plane(2047, -2048, -2048, C_MIN));
        cfg_write(REG_PLANE_BOTTOM, pack_plane(0, 0, 2047, 0));
        box_queue.push_back(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        box_queue.push_back(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        box_queue.push_back(make_box(0, 0, 0, 0, 0, 0));
        box_queue.push_back(make_chunk(32767, -32768, 32767));
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            src_idle_on = (ph != 1 && ph != 5 && ph != 7);
            snk_idle_on = (ph != 1 && ph != 5 && ph != 6);
            span = 1 << $urandom_range(10, 26);
            if (ph == 3)
            begin
                for (int p = 0; p < PLANE_COUNT; p++)
                begin
                    cfg_write(p, {$urandom(), $urandom()});
                end
            end
            else
            begin
                // Three slabs of random orientation, each bounded by opposite planes.
                for (int k = 0; k < 3; k++)
                begin
                    nx = $signed(NORMAL_W'($urandom()));
                    ny = $signed(NORMAL_W'($urandom()));
                    nz = $signed(NORMAL_W'($urandom()));
                    cfg_write(REG_PLANE_LEFT + 2 * k,
                              pack_plane(nx, ny, nz, $urandom_range(0, span)));
                    cfg_write(REG_PLANE_RIGHT + 2 * k,
                              pack_plane(neg_normal(nx), neg_normal(ny), neg_normal(nz),
                                         $urandom_range(0, span)));
                end
            end
            case (ph)
                1:       cfg_write(REG_EXTENT, 64'd1);
                4:       cfg_write(REG_EXTENT, 64'd65535);
                default: cfg_write(REG_EXTENT, 64'($urandom_range(1, 65535)));
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                box_queue.push_back(random_box(span));
            end
            wait_idle();
        end

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
